[rtl/fha_pkg.sv]
// Shared constants, microcode word layout and codes for the first-fit heap allocator.
package fha_pkg;

  // Heap geometry
  localparam int HEAP_WORDS = 64;
  localparam int ADDR_W     = $clog2(HEAP_WORDS);
  localparam int CUR_W      = ADDR_W + 2;
  localparam int HDR_W      = 10;
  localparam int BYTES_W    = 9;
  localparam int RND_W      = 10;
  localparam int WORD_SH    = 3;
  localparam int SIZE_W     = HDR_W - WORD_SH;

  localparam logic [HDR_W-1:0] HDR_RESET = HDR_W'((HEAP_WORDS - 1) * 8);

  // Result status codes
  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_FREED   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  // Microprogram step addresses
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] UPC_IDLE     = 4'd0;
  localparam logic [UPC_W-1:0] UPC_DISPATCH = 4'd1;
  localparam logic [UPC_W-1:0] UPC_A_CHK    = 4'd2;
  localparam logic [UPC_W-1:0] UPC_A_RD     = 4'd3;
  localparam logic [UPC_W-1:0] UPC_A_TEST   = 4'd4;
  localparam logic [UPC_W-1:0] UPC_GRANT    = 4'd5;
  localparam logic [UPC_W-1:0] UPC_SPLIT    = 4'd6;
  localparam logic [UPC_W-1:0] UPC_F_CHK    = 4'd7;
  localparam logic [UPC_W-1:0] UPC_F_TEST   = 4'd8;
  localparam logic [UPC_W-1:0] UPC_RESP     = 4'd9;
  localparam logic [UPC_W-1:0] UPC_LAST     = UPC_RESP;

  // Header read address select
  typedef enum logic [1:0] {
    RD_NONE,
    RD_CUR,
    RD_FREE
  } rd_sel_e;

  // Header write select
  typedef enum logic [1:0] {
    WR_NONE,
    WR_GRANT,
    WR_SPLIT,
    WR_FREE
  } wr_sel_e;

  // Jump conditions
  typedef enum logic [3:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_NO_IN,
    JC_IS_FREE,
    JC_REQ_ZERO,
    JC_WALK_END,
    JC_NOT_FIT,
    JC_ADDR_ZERO,
    JC_OUT_BUSY
  } jc_e;

  // One control word
  typedef struct packed {
    logic             accept;
    rd_sel_e          rd;
    wr_sel_e          wr;
    logic             step_cur;
    logic             out_load;
    jc_e              cond;
    logic [UPC_W-1:0] target;
    logic             ret;
  } uword_t;

endpackage

[rtl/first_fit_heap_allocator.sv]
// Steps: a free checks the block address, reads the header before it and clears its used
// bit; an allocate checks the size, then reads and tests headers until one fits, grants it
// and writes the header of any split remainder. One item at a time; the walk reads each
// header that it visits through the single read port of the header memory.
// A new item is taken while a finished result still waits in the output register.
// Reset (asynchronous, active low) empties the output and makes word 0 read as one
// free block of 504 bytes; the other header words hold nothing until written.
module first_fit_heap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // request_bytes[8:0], block_address[14:9], zero pad
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // payload_address[5:0], zero pad
  output logic [1:0]  m_axis_tuser    // status
);
  import fha_pkg::*;

  uword_t uw;

  logic [UPC_W-1:0]   upc_q, upc_d;
  logic               kind_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [CUR_W-1:0]   cur_q, cur_d;
  logic [1:0]         st_q, st_d;
  logic [ADDR_W-1:0]  pay_q, pay_d;
  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_st_q;
  logic [ADDR_W-1:0]  out_pay_q;
  logic               w0_wr_q, w0_wr_d;
  logic               rd_dflt_q;
  logic [HDR_W-1:0]   rd_data_q;

  logic [HDR_W-1:0]   hdr_mem [HEAP_WORDS];

  logic               in_xfer;
  logic               out_busy;
  logic               out_load;
  logic               cond_hit;
  logic [HDR_W-1:0]   hdr;
  logic               used;
  logic [SIZE_W-1:0]  size_words;
  logic [RND_W-1:0]   size_b;
  logic [RND_W-1:0]   rnd;
  logic [RND_W-1:0]   left;
  logic               fit;
  logic               split;
  logic [CUR_W-1:0]   rem;
  logic [ADDR_W-1:0]  faddr;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [HDR_W-1:0]   wr_data;

  fha_ucode_rom u_rom (
    .upc_i   (upc_q),
    .uword_o (uw)
  );

  // Handshake
  assign s_axis_tready = uw.accept;
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign out_busy      = out_valid_q & ~m_axis_tready;
  assign out_load      = uw.out_load & ~out_busy;

  // Header fields and fit arithmetic
  assign hdr        = rd_dflt_q ? HDR_RESET : rd_data_q;
  assign used       = hdr[0];
  assign size_words = hdr[HDR_W-1:WORD_SH];
  assign size_b     = {size_words, {WORD_SH{1'b0}}};
  assign rnd        = (RND_W'(bytes_q) + RND_W'(7)) & ~RND_W'(7);
  assign fit        = ~used & (size_b >= rnd);
  assign left       = size_b - rnd;
  assign split      = left[RND_W-1:WORD_SH] != '0;
  assign rem        = cur_q + CUR_W'(rnd[RND_W-1:WORD_SH]) + CUR_W'(1);
  assign faddr      = addr_q - ADDR_W'(1);

  // Evaluate the jump condition
  always_comb begin
    case (uw.cond)
      JC_NEVER:     cond_hit = 1'b0;
      JC_ALWAYS:    cond_hit = 1'b1;
      JC_NO_IN:     cond_hit = ~s_axis_tvalid;
      JC_IS_FREE:   cond_hit = kind_q;
      JC_REQ_ZERO:  cond_hit = bytes_q == '0;
      JC_WALK_END:  cond_hit = cur_q >= CUR_W'(HEAP_WORDS);
      JC_NOT_FIT:   cond_hit = ~fit;
      JC_ADDR_ZERO: cond_hit = addr_q == '0;
      JC_OUT_BUSY:  cond_hit = out_busy;
      default:      cond_hit = 1'b0;
    endcase
  end

  // Sequence: jump, return to idle, or advance
  always_comb begin
    if (cond_hit) begin
      upc_d = uw.target;
    end else if (uw.ret) begin
      upc_d = UPC_IDLE;
    end else begin
      upc_d = upc_q + UPC_W'(1);
    end
  end

  // Select header read port
  always_comb begin
    case (uw.rd)
      RD_CUR: begin
        rd_en   = 1'b1;
        rd_addr = cur_q[ADDR_W-1:0];
      end
      RD_FREE: begin
        rd_en   = 1'b1;
        rd_addr = faddr;
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = cur_q[ADDR_W-1:0];
      end
    endcase
  end

  // Select header write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_q[ADDR_W-1:0];
    wr_data = hdr;
    case (uw.wr)
      WR_GRANT: begin
        wr_en   = 1'b1;
        wr_data = split ? (rnd | HDR_W'(1)) : (size_b | HDR_W'(1));
      end
      WR_SPLIT: begin
        wr_en   = split & (rem < CUR_W'(HEAP_WORDS));
        wr_addr = rem[ADDR_W-1:0];
        wr_data = left - RND_W'(8);
      end
      WR_FREE: begin
        wr_en   = used;
        wr_addr = faddr;
        wr_data = hdr & ~HDR_W'(1);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Working result and walk cursor
  always_comb begin
    cur_d = cur_q;
    st_d  = st_q;
    pay_d = pay_q;
    if (in_xfer) begin
      cur_d = '0;
      st_d  = s_axis_tuser ? ST_IGNORED : ST_NOFIT;
      pay_d = '0;
    end else if (uw.step_cur && !fit) begin
      cur_d = cur_q + CUR_W'(size_words) + CUR_W'(1);
    end else if (uw.wr == WR_GRANT) begin
      st_d  = ST_ALLOC;
      pay_d = cur_q[ADDR_W-1:0] + ADDR_W'(1);
    end else if (uw.wr == WR_FREE && used) begin
      st_d  = ST_FREED;
    end
  end

  assign out_valid_d = out_load | out_busy;
  assign w0_wr_d     = w0_wr_q | (wr_en & (wr_addr == '0));

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= UPC_IDLE;
      out_valid_q <= 1'b0;
      w0_wr_q     <= 1'b0;
      rd_dflt_q   <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
      w0_wr_q     <= w0_wr_d;
      if (rd_en) begin
        rd_dflt_q <= (rd_addr == '0) & ~w0_wr_q;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q  <= s_axis_tuser;
      bytes_q <= s_axis_tdata[BYTES_W-1:0];
      addr_q  <= s_axis_tdata[BYTES_W+ADDR_W-1:BYTES_W];
    end
    cur_q <= cur_d;
    st_q  <= st_d;
    pay_q <= pay_d;
    if (out_load) begin
      out_st_q  <= st_q;
      out_pay_q <= pay_q;
    end
  end

  // Header memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hdr_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= hdr_mem[rd_addr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tdata  = {{(8 - ADDR_W){1'b0}}, out_pay_q};

`ifndef SYNTHESIS
  a_no_load_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !out_load)
    else $error("result loaded over a stalled output");

  a_test_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == UPC_A_TEST) |-> (cur_q < CUR_W'(HEAP_WORDS)))
    else $error("header tested beyond the heap");

  a_grant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == UPC_GRANT) |=> (st_q == ST_ALLOC))
    else $error("grant did not set the allocated status");

  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q <= UPC_LAST)
    else $error("step counter outside the program");

  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (upc_q == UPC_DISPATCH))
    else $error("transfer did not start the dispatch step");
`endif

endmodule

[rtl/fha_ucode_rom.sv]
// Microprogram table of the allocator sequencer.
module fha_ucode_rom (
  input  logic [fha_pkg::UPC_W-1:0] upc_i,
  output fha_pkg::uword_t           uword_o
);
  import fha_pkg::*;

  // Look up the control word of the current step
  always_comb begin
    uword_o = '{accept: 1'b0, rd: RD_NONE, wr: WR_NONE, step_cur: 1'b0,
                out_load: 1'b0, cond: JC_NEVER, target: UPC_IDLE, ret: 1'b0};
    case (upc_i)
      UPC_IDLE: begin
        uword_o.accept = 1'b1;
        uword_o.cond   = JC_NO_IN;
        uword_o.target = UPC_IDLE;
      end
      UPC_DISPATCH: begin
        uword_o.cond   = JC_IS_FREE;
        uword_o.target = UPC_F_CHK;
      end
      UPC_A_CHK: begin
        uword_o.cond   = JC_REQ_ZERO;
        uword_o.target = UPC_RESP;
      end
      UPC_A_RD: begin
        uword_o.rd     = RD_CUR;
        uword_o.cond   = JC_WALK_END;
        uword_o.target = UPC_RESP;
      end
      UPC_A_TEST: begin
        uword_o.step_cur = 1'b1;
        uword_o.cond     = JC_NOT_FIT;
        uword_o.target   = UPC_A_RD;
      end
      UPC_GRANT: begin
        uword_o.wr = WR_GRANT;
      end
      UPC_SPLIT: begin
        uword_o.wr     = WR_SPLIT;
        uword_o.cond   = JC_ALWAYS;
        uword_o.target = UPC_RESP;
      end
      UPC_F_CHK: begin
        uword_o.rd     = RD_FREE;
        uword_o.cond   = JC_ADDR_ZERO;
        uword_o.target = UPC_RESP;
      end
      UPC_F_TEST: begin
        uword_o.wr = WR_FREE;
      end
      UPC_RESP: begin
        uword_o.out_load = 1'b1;
        uword_o.cond     = JC_OUT_BUSY;
        uword_o.target   = UPC_RESP;
        uword_o.ret      = 1'b1;
      end
      default: begin
        uword_o.cond   = JC_ALWAYS;
        uword_o.target = UPC_IDLE;
      end
    endcase
  end

endmodule

[tb/sv/first_fit_heap_allocator_tb.sv]
// Self-checking testbench for the first-fit heap allocator: stream driver, monitor, heap predictor.
`timescale 1ns / 100ps

module first_fit_heap_allocator_tb;
  import fha_pkg::*;

  localparam int RANDOM_REQS = 950;
  localparam int QUIET_TAIL  = 100;
  localparam int DRAIN_WAIT  = 140;
  localparam int CYCLE_LIMIT = 700000;
  localparam int LONG_HOLD   = 400;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_kind_e;

  // How a free request gets its address when it is offered
  typedef enum logic [1:0] {
    ADDR_FIXED,
    ADDR_USED,
    ADDR_ANY
  } addr_pick_e;

  typedef struct {
    req_kind_e            kind;
    logic [BYTES_W-1:0]   bytes;
    logic [ADDR_W-1:0]    addr;
    addr_pick_e           pick;
  } heap_req_t;

  typedef struct {
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
  } heap_resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // request_bytes[8:0], block_address[14:9], zero pad
  logic        s_axis_tuser = 1'b0; // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // payload_address[5:0], zero pad
  logic [1:0]  m_axis_tuser;        // status

  // Heap mirror: header words and which of them have ever been written
  logic [HDR_W-1:0] hdr_mem [HEAP_WORDS];
  logic             hdr_written [HEAP_WORDS];

  heap_req_t  request_q [$];
  heap_resp_t answer_q [$];
  heap_req_t  offered_req;
  heap_req_t  nxt_req;
  heap_resp_t exp_resp;

  int total_reqs = 0;
  int issued_cnt = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int src_gap = 0;
  int sink_gap = 0;
  bit long_hold_done = 1'b0;

  first_fit_heap_allocator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one request to the heap mirror and return the answer it earns
  function automatic heap_resp_t serve_request(heap_req_t r);
    heap_resp_t res;
    int rounded, cur, size, rem;
    res.status = (r.kind == REQ_ALLOC) ? ST_NOFIT : ST_IGNORED;
    res.addr   = '0;
    if (r.kind == REQ_FREE) begin
      if (r.addr != 0 && hdr_mem[r.addr - 1][0]) begin
        hdr_mem[r.addr - 1][0] = 1'b0;
        res.status = ST_FREED;
      end
      return res;
    end
    if (r.bytes == 0) return res;
    rounded = (int'(r.bytes) + 7) & ~7;
    cur = 0;
    // Walk the chain and take the first free block that fits
    while (cur < HEAP_WORDS) begin
      size = int'(hdr_mem[cur]) & ~7;
      if (!hdr_mem[cur][0] && size >= rounded) begin
        if (size - rounded >= 8) begin
          rem = cur + rounded / 8 + 1;
          hdr_mem[cur] = HDR_W'(rounded | 1);
          if (rem < HEAP_WORDS) begin
            hdr_mem[rem] = HDR_W'(size - rounded - 8);
            hdr_written[rem] = 1'b1;
          end
        end else begin
          hdr_mem[cur][0] = 1'b1;
        end
        hdr_written[cur] = 1'b1;
        res.status = ST_ALLOC;
        res.addr   = ADDR_W'(cur + 1);
        return res;
      end
      cur += size / 8 + 1;
    end
    return res;
  endfunction

  // Pick a payload address whose header word is known to exist
  function automatic logic [ADDR_W-1:0] pick_free_addr(addr_pick_e pick);
    int cand [$];
    for (int w = 0; w < HEAP_WORDS - 1; w++) begin
      if (hdr_written[w] && (pick == ADDR_ANY || hdr_mem[w][0])) cand.push_back(w);
    end
    if (cand.size() == 0) return ADDR_W'(1);
    return ADDR_W'(cand[$urandom_range(0, cand.size() - 1)] + 1);
  endfunction

  function automatic logic [BYTES_W-1:0] rand_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return BYTES_W'($urandom_range(1, 32));
    if (roll < 85) return BYTES_W'($urandom_range(33, 120));
    if (roll < 95) return BYTES_W'($urandom_range(121, 504));
    if (roll < 98) return BYTES_W'($urandom_range(505, 511));
    return '0;
  endfunction

  function automatic bit idling_on();
    return (issued_cnt < total_reqs - QUIET_TAIL) && ((issued_cnt / 100) % 3 != 2);
  endfunction

  task automatic push_alloc(input logic [BYTES_W-1:0] bytes);
    heap_req_t r;
    r.kind  = REQ_ALLOC;
    r.bytes = bytes;
    r.addr  = ADDR_W'($urandom_range(0, HEAP_WORDS - 1));
    r.pick  = ADDR_FIXED;
    request_q.push_back(r);
  endtask

  task automatic push_free(input addr_pick_e pick, input logic [ADDR_W-1:0] addr);
    heap_req_t r;
    r.kind  = REQ_FREE;
    r.bytes = BYTES_W'($urandom_range(0, 511));
    r.addr  = addr;
    r.pick  = pick;
    request_q.push_back(r);
  endtask

  // Driver: offer requests, predict each one on its transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        answer_q.push_back(serve_request(offered_req));
        issued_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (request_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (idling_on() && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 18);
          s_axis_tvalid <= 1'b0;
        end else begin
          nxt_req = request_q.pop_front();
          // Resolve the free address against the heap as it stands now
          if (nxt_req.kind == REQ_FREE && nxt_req.pick != ADDR_FIXED)
            nxt_req.addr = pick_free_addr(nxt_req.pick);
          offered_req = nxt_req;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {1'b0, nxt_req.addr, nxt_req.bytes};
          s_axis_tuser  <= nxt_req.kind;
        end
      end
    end
  end

  // Monitor: check each result transfer and pace the ready line
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (answer_q.size() == 0) begin
          $error("result with no request pending: status %0d payload_address %0d",
                 m_axis_tuser, m_axis_tdata[ADDR_W-1:0]);
          fail_cnt++;
        end else begin
          exp_resp = answer_q.pop_front();
          if (m_axis_tuser !== exp_resp.status) begin
            $error("status: expected %0d, actual %0d", exp_resp.status, m_axis_tuser);
            fail_cnt++;
          end
          if (m_axis_tdata[ADDR_W-1:0] !== exp_resp.addr) begin
            $error("payload_address: expected %0d, actual %0d",
                   exp_resp.addr, m_axis_tdata[ADDR_W-1:0]);
            fail_cnt++;
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && issued_cnt >= 150) begin
        // Hold off long enough for the block to back up into its input
        long_hold_done = 1'b1;
        sink_gap = LONG_HOLD - 1;
        m_axis_tready <= 1'b0;
      end else if (idling_on() && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(0, 18);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int roll;
    for (int w = 0; w < HEAP_WORDS; w++) begin
      hdr_mem[w] = '0;
      hdr_written[w] = 1'b0;
    end
    hdr_mem[0] = HDR_RESET;
    hdr_written[0] = 1'b1;

    // Directed: zero and oversized sizes, whole heap, split, double free, word zero
    push_alloc(0);
    push_alloc(511);
    push_alloc(505);
    push_alloc(504);
    push_alloc(1);
    push_free(ADDR_FIXED, 1);
    push_free(ADDR_FIXED, 1);
    push_free(ADDR_FIXED, 0);
    push_alloc(1);
    push_alloc(8);
    push_alloc(9);
    push_alloc(440);
    push_alloc(7);
    push_free(ADDR_FIXED, 3);
    push_alloc(2);
    push_free(ADDR_FIXED, 8);
    push_alloc(256);
    push_alloc(255);
    push_free(ADDR_FIXED, 1);
    push_alloc(8);
    push_free(ADDR_ANY, 0);

    // Random mix of allocates and frees
    for (int i = 0; i < RANDOM_REQS; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) push_alloc(rand_size());
      else if (roll < 93) push_free(ADDR_USED, 0);
      else if (roll < 98) push_free(ADDR_ANY, 0);
      else push_free(ADDR_FIXED, 0);
    end
    total_reqs = request_q.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (issued_cnt < total_reqs || answer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/fha_pkg.sv
rtl/fha_ucode_rom.sv
rtl/first_fit_heap_allocator.sv
tb/sv/first_fit_heap_allocator_tb.sv
